>>> hdl/rc4_stream_cipher_unit_macros.svh
// Assertion macros shared by the RC4 engine modules.
`ifndef RC4_STREAM_CIPHER_UNIT_MACROS_SVH
`define RC4_STREAM_CIPHER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Condition c must hold in the same cycle as condition a.
`define RC4_ASSERT_IMPLY(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (c)) \
    else $error("rc4 check failed");

// Condition c must hold in the cycle after condition a.
`define RC4_ASSERT_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (c)) \
    else $error("rc4 check failed");

`else

`define RC4_ASSERT_IMPLY(lbl, clk, rstn, a, c)
`define RC4_ASSERT_NEXT(lbl, clk, rstn, a, c)

`endif

`endif

>>> hdl/rc4_pkg.sv
// Shared types and constants of the RC4 engine.
`default_nettype none

package rc4_pkg;

  // Opcode of an input transaction.
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_DATA = 1'b1;

  // Last step index of the key schedule.
  localparam logic [7:0] SCHED_LAST = 8'd255;

  typedef logic [7:0] byte_t;

  // Sequencer states: keystream step and key schedule.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_D_J,
    ST_D_T,
    ST_D_WR,
    ST_K_CLR,
    ST_K_RD,
    ST_K_B,
    ST_K_C,
    ST_K_D
  } state_t;

  // Request to the permutation memory for one cycle.
  typedef struct packed {
    logic  clr;
    byte_t rd_addr;
    logic  wr_en;
    byte_t wr_addr;
    byte_t wr_data;
  } perm_req_t;

  // One result item.
  typedef struct packed {
    byte_t byte_out;
    logic  msg_last;
  } res_t;

endpackage

`default_nettype wire

>>> hdl/rc4_in_if.sv
// Input channel of the RC4 engine: key and data bytes.
`default_nettype none

interface rc4_in_if;
  logic              valid;
  logic              ready;
  logic              opcode;
  rc4_pkg::byte_t    byte_in;
  logic              last;

  modport source (output valid, output opcode, output byte_in, output last, input ready);
  modport sink   (input valid, input opcode, input byte_in, input last, output ready);
endinterface

`default_nettype wire

>>> hdl/rc4_out_if.sv
// Result channel of the RC4 engine: processed data bytes.
`default_nettype none

interface rc4_out_if;
  logic              valid;
  logic              ready;
  rc4_pkg::byte_t    byte_out;
  logic              msg_last;

  modport source (output valid, output byte_out, output msg_last, input ready);
  modport sink   (input valid, input byte_out, input msg_last, output ready);
endinterface

`default_nettype wire

>>> hdl/rc4_perm_mem.sv
// Permutation memory: 256 bytes, one read and one write port, registered read.
`default_nettype none

module rc4_perm_mem (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rc4_pkg::perm_req_t  req,
  output rc4_pkg::byte_t           rd_data
);

  rc4_pkg::byte_t mem [256];
  logic [255:0]   vld_r;
  rc4_pkg::byte_t rd_data_r;

  // Storage write.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Written-entry flags; an unwritten entry reads as its own address (identity).
  always_ff @(posedge clk) begin
    if (!rst_n || req.clr) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  // Registered read with write-first forwarding on an address match.
  always_ff @(posedge clk) begin
    if (req.wr_en && (req.wr_addr == req.rd_addr)) begin
      rd_data_r <= req.wr_data;
    end else if (vld_r[req.rd_addr]) begin
      rd_data_r <= mem[req.rd_addr];
    end else begin
      rd_data_r <= req.rd_addr;
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> hdl/rc4_key_mem.sv
// Key byte memory: one write port, one registered read port.
`default_nettype none

module rc4_key_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire rc4_pkg::byte_t  wr_data,
  input  wire logic [AW-1:0]   rd_addr,
  output rc4_pkg::byte_t       rd_data
);

  rc4_pkg::byte_t mem [DEPTH];
  rc4_pkg::byte_t rd_data_r;

  // Write of an incoming key byte.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read for the key schedule.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> hdl/rc4_ctrl.sv
// Sequencer of the RC4 engine: key loading, key schedule and keystream steps.
`default_nettype none
`include "rc4_stream_cipher_unit_macros.svh"

module rc4_ctrl #(
  parameter int KEY_MAX = 256,
  parameter int KA_W    = 8,
  parameter int KC_W    = 9
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // Input transaction.
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_opcode,
  input  wire rc4_pkg::byte_t      in_byte,
  input  wire logic                in_last,
  // Result slot.
  input  wire logic                out_free,
  output logic                     res_valid,
  output rc4_pkg::res_t            res,
  // Permutation memory.
  output rc4_pkg::perm_req_t       perm_req,
  input  wire rc4_pkg::byte_t      perm_rd,
  // Key memory.
  output logic                     key_wr_en,
  output logic [KA_W-1:0]          key_wr_addr,
  output logic [KA_W-1:0]          key_rd_addr,
  input  wire rc4_pkg::byte_t      key_rd
);

  localparam int PW = KC_W + 1;

  rc4_pkg::state_t state_r, state_nxt;
  rc4_pkg::byte_t  i_r, i_nxt;
  rc4_pkg::byte_t  j_r, j_nxt;
  logic [KC_W-1:0] key_count_r, key_count_nxt;
  rc4_pkg::byte_t  si_r, si_nxt;
  rc4_pkg::byte_t  t_r, t_nxt;
  rc4_pkg::byte_t  byte_r, byte_nxt;
  logic            last_r, last_nxt;
  rc4_pkg::byte_t  k_r, k_nxt;
  rc4_pkg::byte_t  acc_r, acc_nxt;
  rc4_pkg::byte_t  sk_r, sk_nxt;
  logic [KA_W-1:0] pos_r, pos_nxt;
  logic [KC_W-1:0] len_r, len_nxt;

  logic            key_end;
  logic            pos_wrap;
  logic            sched_busy;
  rc4_pkg::byte_t  ks;

  // The key ends on a flagged byte or when the key memory is full.
  assign key_end  = in_last || (key_count_r == KC_W'(KEY_MAX - 1));
  assign pos_wrap = (PW'(pos_r) + PW'(1)) >= PW'(len_r);
  assign sched_busy = (state_r == rc4_pkg::ST_K_CLR) || (state_r == rc4_pkg::ST_K_RD) ||
                      (state_r == rc4_pkg::ST_K_B) || (state_r == rc4_pkg::ST_K_C) ||
                      (state_r == rc4_pkg::ST_K_D);

  // Keystream byte: the swapped entry at j holds the old value at i.
  assign ks = (t_r == j_r) ? si_r : perm_rd;

  assign res.byte_out = byte_r ^ ks;
  assign res.msg_last = last_r;
  assign key_wr_addr  = key_count_r[KA_W-1:0];

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rc4_pkg::ST_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      key_count_r <= '0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      key_count_r <= key_count_nxt;
    end
  end

  // Working registers of the current step.
  always_ff @(posedge clk) begin
    si_r   <= si_nxt;
    t_r    <= t_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    k_r    <= k_nxt;
    acc_r  <= acc_nxt;
    sk_r   <= sk_nxt;
    pos_r  <= pos_nxt;
    len_r  <= len_nxt;
  end

  // Next state and memory requests.
  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    key_count_nxt = key_count_r;
    si_nxt        = si_r;
    t_nxt         = t_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    k_nxt         = k_r;
    acc_nxt       = acc_r;
    sk_nxt        = sk_r;
    pos_nxt       = pos_r;
    len_nxt       = len_r;
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    key_wr_en     = 1'b0;
    key_rd_addr   = pos_r;
    perm_req         = '0;
    perm_req.rd_addr = i_r + 8'd1;

    case (state_r)
      rc4_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      // S[i] is back: advance j and read S[j].
      rc4_pkg::ST_D_J: begin
        si_nxt           = perm_rd;
        j_nxt            = j_r + perm_rd;
        perm_req.rd_addr = j_r + perm_rd;
        state_nxt        = rc4_pkg::ST_D_T;
      end
      // S[j] is back: write it to S[i] and read S[S[i] + S[j]].
      rc4_pkg::ST_D_T: begin
        perm_req.wr_en   = 1'b1;
        perm_req.wr_addr = i_r;
        perm_req.wr_data = perm_rd;
        t_nxt            = si_r + perm_rd;
        perm_req.rd_addr = si_r + perm_rd;
        state_nxt        = rc4_pkg::ST_D_WR;
      end
      // Finish the swap and hand over the result once the slot is free.
      rc4_pkg::ST_D_WR: begin
        perm_req.wr_en   = 1'b1;
        perm_req.wr_addr = j_r;
        perm_req.wr_data = si_r;
        if (out_free) begin
          res_valid = 1'b1;
          in_ready  = 1'b1;
          state_nxt = rc4_pkg::ST_IDLE;
        end else begin
          perm_req.rd_addr = t_r;
        end
      end
      // Return the permutation to identity.
      rc4_pkg::ST_K_CLR: begin
        perm_req.clr = 1'b1;
        state_nxt    = rc4_pkg::ST_K_RD;
      end
      rc4_pkg::ST_K_RD: begin
        perm_req.rd_addr = 8'd0;
        key_rd_addr      = '0;
        k_nxt            = 8'd0;
        acc_nxt          = 8'd0;
        pos_nxt          = '0;
        state_nxt        = rc4_pkg::ST_K_B;
      end
      // S[k] and the key byte are back: update the accumulator, read S[acc].
      rc4_pkg::ST_K_B: begin
        sk_nxt           = perm_rd;
        acc_nxt          = acc_r + perm_rd + key_rd;
        perm_req.rd_addr = acc_r + perm_rd + key_rd;
        state_nxt        = rc4_pkg::ST_K_C;
      end
      rc4_pkg::ST_K_C: begin
        perm_req.wr_en   = 1'b1;
        perm_req.wr_addr = k_r;
        perm_req.wr_data = perm_rd;
        state_nxt        = rc4_pkg::ST_K_D;
      end
      // Finish the swap and start reading the next step, or return to idle after the last step.
      rc4_pkg::ST_K_D: begin
        perm_req.wr_en   = 1'b1;
        perm_req.wr_addr = acc_r;
        perm_req.wr_data = sk_r;
        if (k_r == rc4_pkg::SCHED_LAST) begin
          i_nxt     = 8'd0;
          j_nxt     = 8'd0;
          state_nxt = rc4_pkg::ST_IDLE;
        end else begin
          k_nxt            = k_r + 8'd1;
          pos_nxt          = pos_wrap ? '0 : pos_r + KA_W'(1);
          perm_req.rd_addr = k_r + 8'd1;
          key_rd_addr      = pos_wrap ? '0 : pos_r + KA_W'(1);
          state_nxt        = rc4_pkg::ST_K_B;
        end
      end
      default: begin
        state_nxt = rc4_pkg::ST_IDLE;
      end
    endcase

    // Accepted transaction: start a keystream step or store a key byte.
    if (in_ready && in_valid) begin
      if (in_opcode == rc4_pkg::OP_DATA) begin
        i_nxt     = i_r + 8'd1;
        byte_nxt  = in_byte;
        last_nxt  = in_last;
        state_nxt = rc4_pkg::ST_D_J;
      end else begin
        key_wr_en = 1'b1;
        if (key_end) begin
          len_nxt       = key_count_r + KC_W'(1);
          key_count_nxt = '0;
          state_nxt     = rc4_pkg::ST_K_CLR;
        end else begin
          key_count_nxt = key_count_r + KC_W'(1);
        end
      end
    end
  end

  // No transaction is taken while the key schedule runs.
  `RC4_ASSERT_IMPLY(a_sched_blocks_input, clk, rst_n, sched_busy, !in_ready)
  // A result is only issued into a free output slot.
  `RC4_ASSERT_IMPLY(a_result_has_slot, clk, rst_n, res_valid, out_free && (state_r == rc4_pkg::ST_D_WR))
  // A key byte that ends the key starts the schedule.
  `RC4_ASSERT_NEXT(a_key_end_starts_sched, clk, rst_n, in_valid && in_ready && (in_opcode == rc4_pkg::OP_KEY) && key_end, (state_r == rc4_pkg::ST_K_CLR) && (key_count_r == '0))
  // The key count never reaches the key memory depth.
  `RC4_ASSERT_IMPLY(a_key_count_range, clk, rst_n, 1'b1, key_count_r <= KC_W'(KEY_MAX - 1))
  // A data transaction is always followed by the read of S[j].
  `RC4_ASSERT_NEXT(a_data_step_order, clk, rst_n, in_valid && in_ready && (in_opcode == rc4_pkg::OP_DATA), state_r == rc4_pkg::ST_D_J)

endmodule

`default_nettype wire

>>> hdl/rc4_stream_cipher_unit.sv
// Top level of the RC4 engine: memories, sequencer and output register.
`default_nettype none

// RC4 stream cipher engine. Key bytes (opcode 0) are taken one per cycle
// while idle and stored in order; the byte flagged last, or the KEY_MAX-th
// byte, ends the key and starts the key schedule. The schedule returns the
// permutation to identity, starts the first read, then runs 256 steps
// through ST_K_B, ST_K_C and ST_K_D; no transaction is accepted during it.
// Each data byte (opcode 1) steps the keystream generator once and returns
// the byte XORed with the keystream byte, with its last flag echoed. A data
// byte passes through ST_D_J, ST_D_T and ST_D_WR, set by three dependent
// reads of the single-read-port permutation memory, so a new data
// transaction is accepted only once the last one hands over its result. The
// output register lets the next transaction enter while a result waits.
// Before any key is loaded the generator runs on the identity permutation.

module rc4_stream_cipher_unit #(
  parameter int KEY_MAX = 256
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rc4_in_if.sink     in_ch,
  rc4_out_if.source  out_ch
);

  localparam int KA_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int KC_W = $clog2(KEY_MAX + 1);

  rc4_pkg::perm_req_t perm_req;
  rc4_pkg::byte_t     perm_rd;
  logic               key_wr_en;
  logic [KA_W-1:0]    key_wr_addr;
  logic [KA_W-1:0]    key_rd_addr;
  rc4_pkg::byte_t     key_rd;
  logic               res_valid;
  rc4_pkg::res_t      res;
  logic               out_free;

  logic               out_valid_r;
  rc4_pkg::res_t      out_res_r;

  rc4_perm_mem u_perm_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (perm_req),
    .rd_data (perm_rd)
  );

  rc4_key_mem #(
    .DEPTH (KEY_MAX),
    .AW    (KA_W)
  ) u_key_mem (
    .clk     (clk),
    .wr_en   (key_wr_en),
    .wr_addr (key_wr_addr),
    .wr_data (in_ch.byte_in),
    .rd_addr (key_rd_addr),
    .rd_data (key_rd)
  );

  rc4_ctrl #(
    .KEY_MAX (KEY_MAX),
    .KA_W    (KA_W),
    .KC_W    (KC_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_opcode   (in_ch.opcode),
    .in_byte     (in_ch.byte_in),
    .in_last     (in_ch.last),
    .out_free    (out_free),
    .res_valid   (res_valid),
    .res         (res),
    .perm_req    (perm_req),
    .perm_rd     (perm_rd),
    .key_wr_en   (key_wr_en),
    .key_wr_addr (key_wr_addr),
    .key_rd_addr (key_rd_addr),
    .key_rd      (key_rd)
  );

  // The slot is free when empty or drained in this cycle.
  assign out_free = !out_valid_r || out_ch.ready;

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.byte_out = out_res_r.byte_out;
  assign out_ch.msg_last = out_res_r.msg_last;

endmodule

`default_nettype wire
